>>> rtl/core/assert_macros.svh
// Assertion macros shared by the ancestor engine RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> rtl/core/blle_pkg.sv
// Types and constants shared by the ancestor engine controller and datapath.
package blle_pkg;

  localparam int ACT_W   = 2;
  localparam int NODE_W  = 10;
  localparam int STEPS_W = 10;
  localparam int DEPTH_W = 11;

  localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;

  typedef enum logic [ACT_W-1:0] {
    ACT_LOAD = 2'd0,
    ACT_LCA  = 2'd1,
    ACT_KTH  = 2'd2
  } act_t;

  // One jump table entry: an ancestor number and a flag that it exists.
  typedef struct packed {
    logic              present;
    logic [NODE_W-1:0] node;
  } jump_ent_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_L_DEP,
    ST_L_NEXT,
    ST_L_WR,
    ST_Q_DA,
    ST_Q_DB,
    ST_C_STEP,
    ST_C_WAIT,
    ST_Q_LIFT,
    ST_Q_LWAIT,
    ST_Q_LDEP,
    ST_Q_PAR,
    ST_Q_PWAIT,
    ST_FINISH
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_RD_DEP_P,
    OP_LOAD_ROOT,
    OP_LOAD_CHILD,
    OP_FILL_ZERO,
    OP_FILL_RD,
    OP_FILL_WR,
    OP_RD_DA,
    OP_RD_DB,
    OP_ORDER,
    OP_CLIMB_RD,
    OP_CLIMB_MOVE,
    OP_LVL_DOWN,
    OP_LIFT_INIT,
    OP_LIFT_RD,
    OP_LIFT_MOVE,
    OP_LIFT_DEP,
    OP_PAR_RD,
    OP_RES_FAIL,
    OP_RES_A,
    OP_RES_B,
    OP_RES_PAR,
    OP_OUT_LOAD
  } dp_op_t;

  typedef struct packed {
    logic [ACT_W-1:0] act;
    logic             has_p;
    logic             a_ok;
    logic             b_ok;
    logic             p_ok;
    logic             lvl_zero;
    logic             lvl_full;
    logic             k_ge;
    logic             da_ge;
    logic             ab_eq;
    logic             ent_a_present;
    logic             cur_present;
    logic             lift_move;
  } dp_status_t;

endpackage

>>> rtl/core/binary_lifting_lca_engine_core.sv
// Top level of the binary lifting ancestor engine.
//
//   channel   signals                                           handshake
//   input     action node parent_node has_parent other_node     in_valid / in_stall
//             steps
//   output    kind result_node found                            out_valid / out_stall
//
// One item is worked on at a time; every jump table access goes through its
// single write port and two read ports. A load fills its node's row level by
// level; a k-th ancestor query climbs from the top level down, and an LCA query
// also lifts both nodes until their parents meet.
// Reset clears only the controller; the tables are valid once written.
// A finished result waits in the output register while the next item is taken.
`include "assert_macros.svh"

module binary_lifting_lca_engine_core #(
  parameter int MAX_NODES = 1024,
  parameter int LEVELS    = 10
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [blle_pkg::ACT_W-1:0]    action,
  input  logic [blle_pkg::NODE_W-1:0]   node,
  input  logic [blle_pkg::NODE_W-1:0]   parent_node,
  input  logic                          has_parent,
  input  logic [blle_pkg::NODE_W-1:0]   other_node,
  input  logic [blle_pkg::STEPS_W-1:0]  steps,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [blle_pkg::ACT_W-1:0]    kind,
  output logic [blle_pkg::NODE_W-1:0]   result_node,
  output logic                          found
);
  import blle_pkg::*;

  dp_op_t     op;
  dp_status_t status;

  blle_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .status    (status),
    .op        (op),
    .in_stall  (in_stall),
    .out_valid (out_valid)
  );

  blle_dp #(
    .MAX_NODES (MAX_NODES),
    .LEVELS    (LEVELS)
  ) u_dp (
    .clk         (clk),
    .op          (op),
    .action      (action),
    .node        (node),
    .parent_node (parent_node),
    .has_parent  (has_parent),
    .other_node  (other_node),
    .steps       (steps),
    .status      (status),
    .kind        (kind),
    .result_node (result_node),
    .found       (found)
  );

  `ASSERT_NEXT(a_one_item_at_a_time, clk, rst, in_valid && !in_stall, in_stall)
  `ASSERT_IMPLY(a_result_after_work, clk, rst, $rose(out_valid), $past(in_stall))
  `ASSERT_IMPLY(a_miss_gives_zero, clk, rst, out_valid && !found, result_node == '0)
  `ASSERT_IMPLY(a_load_not_found, clk, rst, out_valid && kind == ACT_LOAD, !found)

endmodule

>>> rtl/core/blle_ctrl.sv
// Sequencing state machine of the ancestor engine.
module blle_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 out_stall,
  input  blle_pkg::dp_status_t status,
  output blle_pkg::dp_op_t     op,
  output logic                 in_stall,
  output logic                 out_valid
);
  import blle_pkg::*;

  state_t state, state_next;
  logic   out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (op == OP_OUT_LOAD) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        case (status.act)
          ACT_LOAD: begin
            if (!status.a_ok || (status.has_p && !status.p_ok)) state_next = ST_FINISH;
            else if (status.has_p) state_next = ST_L_DEP;
            else state_next = ST_L_NEXT;
          end
          ACT_LCA: state_next = (status.a_ok && status.b_ok) ? ST_Q_DA : ST_FINISH;
          ACT_KTH: state_next = status.a_ok ? ST_C_STEP : ST_FINISH;
          default: state_next = ST_FINISH;
        endcase
      end
      ST_L_DEP: state_next = ST_L_NEXT;
      ST_L_NEXT: begin
        if (status.lvl_full) state_next = ST_FINISH;
        else if (status.cur_present) state_next = ST_L_WR;
      end
      ST_L_WR: state_next = ST_L_NEXT;
      ST_Q_DA: state_next = ST_Q_DB;
      ST_Q_DB: state_next = ST_C_STEP;
      ST_C_STEP: begin
        if (status.k_ge) state_next = ST_C_WAIT;
        else if (!status.lvl_zero) state_next = ST_C_STEP;
        else if (status.act == ACT_KTH || status.ab_eq) state_next = ST_FINISH;
        else state_next = ST_Q_LIFT;
      end
      ST_C_WAIT: state_next = status.ent_a_present ? ST_C_STEP : ST_FINISH;
      ST_Q_LIFT: begin
        if (status.da_ge) state_next = ST_Q_LWAIT;
        else if (status.lvl_zero) state_next = ST_Q_PWAIT;
      end
      ST_Q_LWAIT: begin
        if (status.lift_move) state_next = ST_Q_LDEP;
        else if (status.lvl_zero) state_next = ST_Q_PWAIT;
        else state_next = ST_Q_LIFT;
      end
      ST_Q_LDEP: state_next = status.lvl_zero ? ST_Q_PAR : ST_Q_LIFT;
      ST_Q_PAR: state_next = ST_Q_PWAIT;
      ST_Q_PWAIT: state_next = ST_FINISH;
      ST_FINISH: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    op = OP_NONE;
    case (state)
      ST_IDLE: begin
        if (in_valid) op = OP_CAPTURE;
      end
      ST_CHECK: begin
        case (status.act)
          ACT_LOAD: begin
            if (!status.a_ok || (status.has_p && !status.p_ok)) op = OP_RES_FAIL;
            else if (status.has_p) op = OP_RD_DEP_P;
            else op = OP_LOAD_ROOT;
          end
          ACT_LCA: op = (status.a_ok && status.b_ok) ? OP_RD_DA : OP_RES_FAIL;
          ACT_KTH: op = status.a_ok ? OP_NONE : OP_RES_FAIL;
          default: op = OP_RES_FAIL;
        endcase
      end
      ST_L_DEP: op = OP_LOAD_CHILD;
      ST_L_NEXT: begin
        if (status.lvl_full) op = OP_RES_FAIL;
        else if (status.cur_present) op = OP_FILL_RD;
        else op = OP_FILL_ZERO;
      end
      ST_L_WR: op = OP_FILL_WR;
      ST_Q_DA: op = OP_RD_DB;
      ST_Q_DB: op = OP_ORDER;
      ST_C_STEP: begin
        if (status.k_ge) op = OP_CLIMB_RD;
        else if (!status.lvl_zero) op = OP_LVL_DOWN;
        else if (status.act == ACT_KTH) op = OP_RES_B;
        else if (status.ab_eq) op = OP_RES_A;
        else op = OP_LIFT_INIT;
      end
      ST_C_WAIT: op = status.ent_a_present ? OP_CLIMB_MOVE : OP_RES_FAIL;
      ST_Q_LIFT: begin
        if (status.da_ge) op = OP_LIFT_RD;
        else if (status.lvl_zero) op = OP_PAR_RD;
        else op = OP_LVL_DOWN;
      end
      ST_Q_LWAIT: begin
        if (status.lift_move) op = OP_LIFT_MOVE;
        else if (status.lvl_zero) op = OP_PAR_RD;
        else op = OP_LVL_DOWN;
      end
      ST_Q_LDEP: op = OP_LIFT_DEP;
      ST_Q_PAR: op = OP_PAR_RD;
      ST_Q_PWAIT: op = OP_RES_PAR;
      ST_FINISH: begin
        if (out_free) op = OP_OUT_LOAD;
      end
      default: op = OP_NONE;
    endcase
  end

endmodule

>>> rtl/core/blle_dp.sv
// Datapath of the ancestor engine: depth store, jump table and work registers.
module blle_dp #(
  parameter int MAX_NODES = 1024,
  parameter int LEVELS    = 10
) (
  input  logic                          clk,
  input  blle_pkg::dp_op_t              op,
  input  logic [blle_pkg::ACT_W-1:0]    action,
  input  logic [blle_pkg::NODE_W-1:0]   node,
  input  logic [blle_pkg::NODE_W-1:0]   parent_node,
  input  logic                          has_parent,
  input  logic [blle_pkg::NODE_W-1:0]   other_node,
  input  logic [blle_pkg::STEPS_W-1:0]  steps,
  output blle_pkg::dp_status_t          status,
  output logic [blle_pkg::ACT_W-1:0]    kind,
  output logic [blle_pkg::NODE_W-1:0]   result_node,
  output logic                          found
);
  import blle_pkg::*;

  localparam int AW     = $clog2(MAX_NODES);
  localparam int JDEPTH = MAX_NODES * LEVELS;
  localparam int JW     = (JDEPTH > 1) ? $clog2(JDEPTH) : 1;
  localparam int LVW    = $clog2(LEVELS + 1);
  localparam logic [LVW-1:0] TOP_LVL = LVW'(LEVELS - 1);

  // Row n of the jump table starts at n * LEVELS.
  function automatic logic [JW-1:0] jaddr(input logic [NODE_W-1:0] n,
                                          input logic [LVW-1:0] l);
    return JW'(JW'(n) * JW'(LEVELS) + JW'(l));
  endfunction

  logic [DEPTH_W-1:0] depth_mem [MAX_NODES];
  jump_ent_t          jump_mem  [JDEPTH];

  logic [DEPTH_W-1:0] dep_rd;
  jump_ent_t          ja_rd, jb_rd;

  logic               dep_we;
  logic [AW-1:0]      dep_waddr, dep_raddr;
  logic [DEPTH_W-1:0] dep_wdata;
  logic               j_we;
  logic [JW-1:0]      j_waddr, ja_raddr, jb_raddr;
  jump_ent_t          j_wdata;

  logic [ACT_W-1:0]   act;
  logic [NODE_W-1:0]  a, b, p;
  logic               has_p;
  logic [DEPTH_W-1:0] k, da;
  logic [LVW-1:0]     lvl;
  jump_ent_t          cur;
  logic [NODE_W-1:0]  res_node;
  logic               res_ok;

  logic [DEPTH_W-1:0] dep_inc;
  logic [LVW-1:0]     lvl_m1;
  logic [DEPTH_W-1:0] k_step;

  assign dep_inc = (dep_rd == DEPTH_MAX) ? DEPTH_MAX : dep_rd + DEPTH_W'(1);
  assign lvl_m1  = lvl - LVW'(1);
  assign k_step  = DEPTH_W'(1) << lvl;

  always_comb begin
    status.act           = act;
    status.has_p         = has_p;
    status.a_ok          = 32'(a) < 32'(MAX_NODES);
    status.b_ok          = 32'(b) < 32'(MAX_NODES);
    status.p_ok          = 32'(p) < 32'(MAX_NODES);
    status.lvl_zero      = (lvl == '0);
    status.lvl_full      = (lvl == LVW'(LEVELS));
    status.k_ge          = ((k >> lvl) != '0);
    status.da_ge         = ((da >> lvl) != '0);
    status.ab_eq         = (a == b);
    status.ent_a_present = ja_rd.present;
    status.cur_present   = cur.present;
    // The pair moves only when both jumps exist and still differ.
    status.lift_move     = ja_rd.present && jb_rd.present && (ja_rd != jb_rd);
  end

  always_comb begin
    dep_we    = 1'b0;
    dep_waddr = AW'(a);
    dep_wdata = '0;
    dep_raddr = AW'(a);
    j_we      = 1'b0;
    j_waddr   = jaddr(a, lvl);
    j_wdata   = '0;
    ja_raddr  = jaddr(a, lvl);
    jb_raddr  = jaddr(b, lvl);
    case (op)
      OP_RD_DEP_P: dep_raddr = AW'(p);
      OP_LOAD_ROOT: begin
        dep_we    = 1'b1;
        dep_wdata = DEPTH_W'(1);
        j_we      = 1'b1;
        j_waddr   = jaddr(a, '0);
      end
      OP_LOAD_CHILD: begin
        dep_we    = 1'b1;
        dep_wdata = dep_inc;
        j_we      = 1'b1;
        j_waddr   = jaddr(a, '0);
        j_wdata   = jump_ent_t'{present: 1'b1, node: p};
      end
      OP_FILL_ZERO: j_we = 1'b1;
      OP_FILL_RD:   ja_raddr = jaddr(cur.node, lvl_m1);
      OP_FILL_WR: begin
        j_we    = 1'b1;
        j_wdata = ja_rd;
      end
      OP_RD_DB:     dep_raddr = AW'(b);
      OP_CLIMB_RD:  ja_raddr = jaddr(b, lvl);
      OP_LIFT_MOVE: dep_raddr = AW'(ja_rd.node);
      OP_PAR_RD:    ja_raddr = jaddr(a, '0);
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (dep_we) depth_mem[dep_waddr] <= dep_wdata;
    dep_rd <= depth_mem[dep_raddr];
    if (j_we) jump_mem[j_waddr] <= j_wdata;
    ja_rd <= jump_mem[ja_raddr];
    jb_rd <= jump_mem[jb_raddr];
  end

  always_ff @(posedge clk) begin
    case (op)
      OP_CAPTURE: begin
        act   <= action;
        a     <= node;
        b     <= (action == ACT_KTH) ? node : other_node;
        p     <= parent_node;
        has_p <= has_parent;
        k     <= DEPTH_W'(steps);
        lvl   <= TOP_LVL;
      end
      OP_LOAD_ROOT: begin
        cur <= '0;
        lvl <= LVW'(1);
      end
      OP_LOAD_CHILD: begin
        cur <= jump_ent_t'{present: 1'b1, node: p};
        lvl <= LVW'(1);
      end
      OP_FILL_ZERO: lvl <= lvl + LVW'(1);
      OP_FILL_WR: begin
        cur <= ja_rd;
        lvl <= lvl + LVW'(1);
      end
      OP_RD_DB: da <= dep_rd;
      OP_ORDER: begin
        // Keep the shallower node in a; b climbs by the depth difference.
        if (da > dep_rd) begin
          a  <= b;
          b  <= a;
          da <= dep_rd;
          k  <= da - dep_rd;
        end else begin
          k <= dep_rd - da;
        end
        lvl <= TOP_LVL;
      end
      OP_CLIMB_MOVE: begin
        b <= ja_rd.node;
        k <= k - k_step;
      end
      OP_LVL_DOWN:  lvl <= lvl_m1;
      OP_LIFT_INIT: lvl <= TOP_LVL;
      OP_LIFT_MOVE: begin
        a <= ja_rd.node;
        b <= jb_rd.node;
      end
      OP_LIFT_DEP: begin
        da <= dep_rd;
        if (lvl != '0) lvl <= lvl_m1;
      end
      OP_RES_FAIL: begin
        res_node <= '0;
        res_ok   <= 1'b0;
      end
      OP_RES_A: begin
        res_node <= a;
        res_ok   <= 1'b1;
      end
      OP_RES_B: begin
        res_node <= b;
        res_ok   <= 1'b1;
      end
      OP_RES_PAR: begin
        res_node <= ja_rd.present ? ja_rd.node : '0;
        res_ok   <= ja_rd.present;
      end
      OP_OUT_LOAD: begin
        kind        <= act;
        result_node <= res_node;
        found       <= res_ok;
      end
      default: begin
      end
    endcase
  end

endmodule
